// ----- hdl/ssf_pkg.sv -----
package ssf_pkg;

  localparam int VALUE_W = 16;
  localparam int DIGIT_W = 4;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 2;

  // floor(v / 10) == (v * 52429) >> 19, exact for v below 81920
  localparam int PROD_W      = 32;
  localparam int RECIP_SHIFT = 19;
  localparam logic [VALUE_W-1:0] RECIP10 = 16'd52429;

  localparam logic [BYTE_W-1:0] SEG_C  = 8'b0000_0001;
  localparam logic [BYTE_W-1:0] SEG_DP = 8'b0000_0010;
  localparam logic [BYTE_W-1:0] SEG_B  = 8'b0000_0100;
  localparam logic [BYTE_W-1:0] SEG_F  = 8'b0000_1000;
  localparam logic [BYTE_W-1:0] SEG_A  = 8'b0001_0000;
  localparam logic [BYTE_W-1:0] SEG_E  = 8'b0010_0000;
  localparam logic [BYTE_W-1:0] SEG_D  = 8'b0100_0000;
  localparam logic [BYTE_W-1:0] SEG_G  = 8'b1000_0000;

  // active-low pattern for one decimal digit, dp always off
  function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    pat = SEG_B | SEG_C;
      4'd2:    pat = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3:    pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    pat = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5:    pat = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd6:    pat = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    pat = SEG_A | SEG_B | SEG_C;
      4'd8:    pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: pat = '0;
    endcase
    return ~pat;
  endfunction

endpackage

// ----- hdl/ssf_if.sv -----
interface ssf_num_if;
  logic                          valid;
  logic                          ready;
  logic [ssf_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ssf_seg_if;
  logic                          valid;
  logic                          ready;
  logic [ssf_pkg::BYTE_W-1:0]    segment_byte;
  logic [ssf_pkg::POS_W-1:0]     digit_position;
  logic                          last;

  modport source (output valid, output segment_byte, output digit_position, output last,
                  input ready);
  modport sink   (input valid, input segment_byte, input digit_position, input last,
                  output ready);
endinterface

// ----- hdl/ssf_front.sv -----
module ssf_front #(
  parameter int DIGITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ssf_num_if.sink                              number,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output logic [DIGITS*ssf_pkg::DIGIT_W-1:0]   push_data
);

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);

  logic                                    busy;
  logic [PW-1:0]                           cnt;
  logic [ssf_pkg::VALUE_W-1:0]             rem;
  logic [DIGITS-1:0][ssf_pkg::DIGIT_W-1:0] digs;

  logic [ssf_pkg::PROD_W-1:0]              prod;
  logic [ssf_pkg::VALUE_W-1:0]             quot;
  logic [ssf_pkg::VALUE_W-1:0]             ten_quot;
  logic [ssf_pkg::VALUE_W-1:0]             diff;
  logic [ssf_pkg::DIGIT_W-1:0]             digit;
  logic [DIGITS:0][ssf_pkg::DIGIT_W-1:0]   digs_ext;
  logic [DIGITS-1:0][ssf_pkg::DIGIT_W-1:0] frame;
  logic                                    step_last;
  logic                                    finishing;
  logic                                    accept;

  // one decimal digit per cycle unless the queue is full, least significant first
  always_comb begin
    prod     = ssf_pkg::PROD_W'(rem) * ssf_pkg::PROD_W'(ssf_pkg::RECIP10);
    quot     = ssf_pkg::VALUE_W'(prod >> ssf_pkg::RECIP_SHIFT);
    ten_quot = ssf_pkg::VALUE_W'(quot << 3) + ssf_pkg::VALUE_W'(quot << 1);
    diff     = rem - ten_quot;
    digit    = diff[ssf_pkg::DIGIT_W-1:0];
    // new digit enters at position 0, earlier ones move toward the LSD slot
    digs_ext = {digs, digit};
    frame    = digs_ext[DIGITS-1:0];
  end

  assign step_last    = busy && (cnt == LAST_POS);
  assign finishing    = step_last && push_ready;
  assign number.ready = !busy || finishing;
  assign accept       = number.valid && number.ready;
  assign push_valid   = step_last;
  assign push_data    = frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (busy && !step_last) begin
      cnt <= cnt + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= number.value;
    end else if (busy && !step_last) begin
      rem  <= quot;
      digs <= frame;
    end
  end

endmodule

// ----- hdl/ssf_fifo.sv -----
module ssf_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [1:0][WIDTH-1:0] slot;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/ssf_back.sv -----
module ssf_back #(
  parameter int DIGITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  logic [DIGITS*ssf_pkg::DIGIT_W-1:0]   pop_data,
  ssf_seg_if.source                            segments
);

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);

  logic [DIGITS-1:0][ssf_pkg::DIGIT_W-1:0] head;
  logic [PW-1:0]                           pos;
  logic                                    load;
  logic                                    at_last;

  assign head      = pop_data;
  assign at_last   = (pos == LAST_POS);
  assign load      = pop_valid && (!segments.valid || segments.ready);
  assign pop_ready = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments.valid <= 1'b0;
      pos            <= '0;
    end else if (load) begin
      segments.valid <= 1'b1;
      pos            <= at_last ? '0 : pos + PW'(1);
    end else if (segments.ready) begin
      segments.valid <= 1'b0;
    end
  end

  // output register holds each byte stable until the driver chain takes it
  always_ff @(posedge clk) begin
    if (load) begin
      segments.segment_byte   <= ssf_pkg::seg_code(head[pos]);
      segments.digit_position <= ssf_pkg::POS_W'(pos);
      segments.last           <= at_last;
    end
  end

endmodule

// ----- hdl/seven_segment_shift_frame.sv -----
// Seven-segment frame encoder. Each value taken on the number channel is cut to
// its lowest DIGITS decimal digits and comes out on the segments channel as
// DIGITS active-low segment bytes, most significant digit first, with last set
// on the final byte so the driver latch can be pulsed. The front splits digits
// with one shared divide-by-ten multiplier, one digit per cycle unless the
// queue is full, and the back emits one byte per cycle while the segments
// channel is ready. A two-frame queue sits between them, so a new value is
// taken while the previous frame is still being sent.
module seven_segment_shift_frame #(
  parameter int DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  ssf_num_if.sink    number,
  ssf_seg_if.source  segments
);

  localparam int FRAME_W = DIGITS * ssf_pkg::DIGIT_W;

  logic               push_valid;
  logic               push_ready;
  logic [FRAME_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [FRAME_W-1:0] pop_data;

  ssf_front #(.DIGITS(DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ssf_fifo #(.WIDTH(FRAME_W)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ssf_back #(.DIGITS(DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .segments  (segments)
  );

endmodule

// ----- hdl/ssf_check.sv -----
module ssf_check #(
  parameter int DIGITS = 4
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         seg_valid,
  input logic                         seg_ready,
  input logic [ssf_pkg::BYTE_W-1:0]   seg_byte,
  input logic [ssf_pkg::POS_W-1:0]    seg_pos,
  input logic                         seg_last
);

  logic seg_xfer;
  assign seg_xfer = seg_valid && seg_ready;

  a_reset_idle: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("segment output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg_byte) && $stable(seg_pos)
      && $stable(seg_last))
    else $error("stalled segment transaction changed");

  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    seg_xfer && !seg_last |=> seg_valid
      && (seg_pos == ssf_pkg::POS_W'($past(seg_pos) + ssf_pkg::POS_W'(1))))
    else $error("frame bytes not contiguous");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_last |-> seg_pos == ssf_pkg::POS_W'(DIGITS - 1))
    else $error("last flag on wrong digit position");

  a_dp_off: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> seg_byte[1])
    else $error("decimal point driven on");

endmodule

bind seven_segment_shift_frame ssf_check #(.DIGITS(DIGITS)) u_ssf_check (
  .clk       (clk),
  .rst       (rst),
  .seg_valid (segments.valid),
  .seg_ready (segments.ready),
  .seg_byte  (segments.segment_byte),
  .seg_pos   (segments.digit_position),
  .seg_last  (segments.last)
);
